/* rtl/core/rled_pkg.sv */
// ----------------------------------------------------------------------------
// rled_pkg
// shared types and constants of the run-length rgb image decoder
// ----------------------------------------------------------------------------
package rled_pkg;

	localparam logic [15:0] DEPTH_WANTED = 16'd24;
	localparam logic [3:0]  HDR_LAST_IDX = 4'd9;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_RUN    = 2'd1,
		KIND_BAD    = 2'd2
	} rled_kind_t;

	typedef struct packed {
		rled_kind_t  kind;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [15:0] row_index;
		logic [15:0] start_column;
		logic [7:0]  run_length;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        line_end;
		logic        image_end;
	} rled_result_t;

endpackage

/* rtl/core/rle_rgb_image_decoder_unit.sv */
// ----------------------------------------------------------------------------
// rle_rgb_image_decoder_unit
// run-length 24-bit rgb image decoder: header parse and run records per byte
// ----------------------------------------------------------------------------
//  port group   | dir | handshake             | beat
//  -------------+-----+-----------------------+---------------------------------
//  input bytes  | in  | in_valid / in_ready   | data_byte, file_start
//  results      | out | out_valid / out_ready | kind, size, run position, colour
//
//  one byte per cycle while no held result stalls the input register; a
//  byte passes the input register and then the result register before its
//  result is on the outputs.
//  reset clears the decode state and both stage valids, no clearing pass.
//  a held result stalls the input register only when that byte has a result.
// ----------------------------------------------------------------------------
module rle_rgb_image_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        file_start,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [15:0] image_width,
	output logic [15:0] image_height,
	output logic [15:0] row_index,
	output logic [15:0] start_column,
	output logic [7:0]  run_length,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        line_end,
	output logic        image_end
);
	import rled_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         start_s1;
	logic         res_valid;
	rled_result_t res;
	rled_result_t res_q;
	logic         space;
	logic         advance;

	// a byte without a result never waits on the output side
	assign advance  = valid_s1 && (!res_valid || space);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			start_s1 <= file_start;
		end
	end

	rled_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.byte_s1   (byte_s1),
		.start_s1  (start_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	rled_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance && res_valid),
		.res_in    (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign kind         = res_q.kind;
	assign image_width  = res_q.image_width;
	assign image_height = res_q.image_height;
	assign row_index    = res_q.row_index;
	assign start_column = res_q.start_column;
	assign run_length   = res_q.run_length;
	assign red          = res_q.red;
	assign green        = res_q.green;
	assign blue         = res_q.blue;
	assign line_end     = res_q.line_end;
	assign image_end    = res_q.image_end;

endmodule

/* rtl/core/rled_parser.sv */
// ----------------------------------------------------------------------------
// rled_parser
// header and run record parser: holds the decode state and forms one result
// ----------------------------------------------------------------------------
module rled_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  logic [7:0]            byte_s1,
	input  logic                  start_s1,
	output logic                  res_valid,
	output rled_pkg::rled_result_t res
);
	import rled_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_RUNS   = 2'd1,
		PH_DONE   = 2'd2,
		PH_BAD    = 2'd3
	} phase_t;

	phase_t      phase_q, phase_e, phase_d;
	logic [3:0]  idx_q, idx_e, idx_d;
	logic [15:0] width_q, width_e, width_d;
	logic [15:0] height_q, height_e, height_d;
	logic [7:0]  dhigh_q, dhigh_e, dhigh_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  blue_q, blue_d;
	logic [7:0]  green_q, green_d;
	logic [15:0] column_q, column_d;
	logic [15:0] row_q, row_d;

	logic [15:0] depth;
	logic        bad;
	logic [15:0] left;
	logic [7:0]  len;
	logic [15:0] col_next;
	logic [15:0] row_next;
	logic [1:0]  ridx;

	always_comb begin
		// file_start clears the header state before this byte is used
		phase_e  = start_s1 ? PH_HEADER : phase_q;
		idx_e    = start_s1 ? 4'd0 : idx_q;
		width_e  = start_s1 ? 16'd0 : width_q;
		height_e = start_s1 ? 16'd0 : height_q;
		dhigh_e  = start_s1 ? 8'd0 : dhigh_q;

		phase_d  = phase_e;
		idx_d    = idx_e;
		width_d  = width_e;
		height_d = height_e;
		dhigh_d  = dhigh_e;
		count_d  = count_q;
		blue_d   = blue_q;
		green_d  = green_q;
		column_d = column_q;
		row_d    = row_q;

		res_valid = 1'b0;
		res       = '0;

		depth    = {dhigh_e, byte_s1};
		bad      = (depth != DEPTH_WANTED) || (width_e == 16'd0) || (height_e == 16'd0);
		left     = width_e - column_q;
		len      = ({8'd0, count_q} < left) ? count_q : left[7:0];
		col_next = column_q + {8'd0, len};
		row_next = row_q + 16'd1;
		ridx     = idx_e[1:0];

		unique case (phase_e) inside
			PH_HEADER: begin
				idx_d = idx_e + 4'd1;
				case (idx_e)
					4'd0: width_d = {byte_s1, width_e[7:0]};
					4'd1: width_d = {width_e[15:8], byte_s1};
					4'd2: height_d = {byte_s1, height_e[7:0]};
					4'd3: height_d = {height_e[15:8], byte_s1};
					4'd8: dhigh_d = byte_s1;
					HDR_LAST_IDX: begin
						res_valid        = 1'b1;
						res.kind         = bad ? KIND_BAD : KIND_HEADER;
						res.image_width  = width_e;
						res.image_height = height_e;
						idx_d    = 4'd0;
						column_d = 16'd0;
						row_d    = 16'd0;
						phase_d  = bad ? PH_BAD : PH_RUNS;
					end
					default: ;
				endcase
			end
			PH_RUNS: begin
				idx_d = {2'd0, ridx + 2'd1};
				case (ridx)
					2'd0: count_d = byte_s1;
					2'd1: blue_d = byte_s1;
					2'd2: green_d = byte_s1;
					default: begin
						if (count_q != 8'd0) begin
							res_valid        = 1'b1;
							res.kind         = KIND_RUN;
							res.image_width  = width_e;
							res.image_height = height_e;
							res.row_index    = row_q;
							res.start_column = column_q;
							res.run_length   = len;
							res.red          = byte_s1;
							res.green        = green_q;
							res.blue         = blue_q;
							column_d = col_next;
							// row covered: wrap to next row, maybe end of image
							if (col_next >= width_e) begin
								res.line_end = 1'b1;
								column_d     = 16'd0;
								row_d        = row_next;
								if (row_next >= height_e) begin
									res.image_end = 1'b1;
									phase_d       = PH_DONE;
								end
							end
						end
					end
				endcase
			end
			PH_DONE, PH_BAD: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			idx_q    <= 4'd0;
			width_q  <= 16'd0;
			height_q <= 16'd0;
			dhigh_q  <= 8'd0;
			count_q  <= 8'd0;
			blue_q   <= 8'd0;
			green_q  <= 8'd0;
			column_q <= 16'd0;
			row_q    <= 16'd0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			width_q  <= width_d;
			height_q <= height_d;
			dhigh_q  <= dhigh_d;
			count_q  <= count_d;
			blue_q   <= blue_d;
			green_q  <= green_d;
			column_q <= column_d;
			row_q    <= row_d;
		end
	end

	a_img_end_line: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.image_end |-> res.line_end)
		else $error("image end without line end");

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.kind == KIND_RUN |-> res.run_length != 8'd0)
		else $error("empty run produced");

	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DONE && !start_s1 |-> !res_valid)
		else $error("result after image end");

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && phase_q == PH_RUNS |=> phase_q != PH_RUNS || column_q < width_q)
		else $error("column beyond row width");

endmodule

/* rtl/core/rled_out_stage.sv */
// ----------------------------------------------------------------------------
// rled_out_stage
// result register with valid/ready handshake toward the consumer
// ----------------------------------------------------------------------------
module rled_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  rled_pkg::rled_result_t res_in,
	output logic                  space,
	output logic                  out_valid,
	input  logic                  out_ready,
	output rled_pkg::rled_result_t res_q
);
	import rled_pkg::*;

	logic valid_q;

	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res_in;
		end
	end

endmodule
